/* hdl/twm_pkg.sv */
// Shared types, constants and register codes for the task liveness window monitor.
package twm_pkg;

    localparam int NUM_REPORTERS = 8;
    localparam int REP_W = (NUM_REPORTERS > 1) ? $clog2(NUM_REPORTERS) : 1;
    localparam int CNT_W = $clog2(NUM_REPORTERS + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORTERS = 3'd5;

    localparam logic [15:0] RST_TICK_MS = 16'd1000;
    localparam logic [7:0] RST_CHECK_INTERVAL = 8'd3;
    localparam logic [15:0] RST_EXPECTED_MS = 16'd1000;
    localparam logic [7:0] RST_MIN_PERCENT = 8'd70;
    localparam logic [7:0] RST_MAX_PERCENT = 8'd120;
    localparam logic [3:0] RST_REPORTERS = 4'd1;

    localparam logic [0:0] CMD_REPORT = 1'b0;
    localparam logic [0:0] CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_WINDOW = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic [17:0] MS_PER_SEC = 18'd1000;

    typedef struct packed {
        logic [15:0] tick_ms;
        logic [7:0] check_interval;
        logic [15:0] expected_ms;
        logic [7:0] min_percent;
        logic [7:0] max_percent;
        logic [CNT_W-1:0] active;
    } t_cfg;

    typedef struct packed {
        logic is_tick;
        logic who_ok;
        logic [2:0] who;
        logic [15:0] amount;
    } t_item;

endpackage

/* hdl/twm_front.sv */
// Front end: accepts input words, classifies them and queues them for the back end.
module twm_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  twm_pkg::t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic [0:0] i_command,
    input  logic [2:0] i_reporter,
    input  logic [15:0] i_amount_ms,
    output logic o_q_valid,
    output twm_pkg::t_item o_q_item,
    input  logic i_q_pop
);

    twm_pkg::t_item r_q [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    twm_pkg::t_item w_item;
    logic w_push;
    logic w_pop;

    always_comb begin
        w_item.is_tick = (i_command == twm_pkg::CMD_TICK);
        w_item.who_ok = ((twm_pkg::CNT_W + 3)'(i_reporter)
                         < (twm_pkg::CNT_W + 3)'(i_cfg.active));
        w_item.who = i_reporter;
        w_item.amount = i_amount_ms;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item = r_q[r_rp];
    assign w_push = i_in_valid && o_in_ready;
    assign w_pop = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* hdl/twm_back.sv */
// Back end: accumulators, elapsed timer, window check walk and the result register.
module twm_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  twm_pkg::t_cfg i_cfg,
    input  logic i_q_valid,
    input  twm_pkg::t_item i_q_item,
    output logic o_q_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_kick,
    output logic o_check_done,
    output logic o_fault,
    output logic [1:0] o_fault_kind,
    output logic [2:0] o_fault_reporter,
    output logic [31:0] o_fault_ms
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TCHK = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [31:0] r_acc [twm_pkg::NUM_REPORTERS];
    logic [31:0] r_elapsed;
    logic r_fault;
    logic [1:0] r_fault_kind;
    logic [2:0] r_fault_reporter;
    logic [31:0] r_fault_ms;
    logic [twm_pkg::CNT_W-1:0] r_idx;
    logic [23:0] r_total;
    logic [31:0] r_plo;
    logic [31:0] r_phi;
    logic r_kick;
    logic r_chk;
    logic r_out_valid;
    logic r_out_kick;
    logic r_out_chk;
    logic r_out_fault;
    logic [1:0] r_out_kind;
    logic [2:0] r_out_reporter;
    logic [31:0] r_out_ms;

    logic [twm_pkg::REP_W-1:0] w_addr;
    logic [31:0] w_acc_rd;
    logic [32:0] w_acc_sum;
    logic [31:0] w_acc_sat;
    logic [32:0] w_el_sum;
    logic [31:0] w_el_sat;
    logic [17:0] w_thr;
    logic [39:0] w_v100;
    logic w_in_win;
    logic w_walk_end;
    logic w_emit_go;

    assign w_addr = (r_state == S_WALK) ? r_idx[twm_pkg::REP_W-1:0]
                                        : twm_pkg::REP_W'(i_q_item.who);
    assign w_acc_rd = r_acc[w_addr];
    assign w_acc_sum = {1'b0, w_acc_rd} + {17'd0, i_q_item.amount};
    assign w_acc_sat = w_acc_sum[32] ? 32'hFFFF_FFFF : w_acc_sum[31:0];
    assign w_el_sum = {1'b0, r_elapsed} + {17'd0, i_cfg.tick_ms};
    assign w_el_sat = w_el_sum[32] ? 32'hFFFF_FFFF : w_el_sum[31:0];
    assign w_thr = 18'(i_cfg.check_interval) * twm_pkg::MS_PER_SEC;
    assign w_v100 = ({8'd0, w_acc_rd} << 6) + ({8'd0, w_acc_rd} << 5)
                  + ({8'd0, w_acc_rd} << 2);
    assign w_in_win = ((w_v100 + 40'd99) >= {8'd0, r_plo}) && (w_v100 <= {8'd0, r_phi});
    assign w_walk_end = (r_idx >= i_cfg.active);
    assign w_emit_go = !r_out_valid || i_out_ready;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_item.is_tick && !r_fault) ? S_TCHK : S_EMIT;
                end
            end
            S_TCHK: n_state = ({14'd0, w_thr} <= r_elapsed) ? S_MUL1 : S_EMIT;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_WALK;
            S_WALK: begin
                if (w_walk_end || !w_in_win) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < twm_pkg::NUM_REPORTERS; k++) begin
                r_acc[k] <= 32'd0;
            end
            r_elapsed <= 32'd0;
            r_fault <= 1'b0;
            r_fault_kind <= twm_pkg::KIND_NONE;
            r_fault_reporter <= 3'd0;
            r_fault_ms <= 32'd0;
            r_idx <= '0;
            r_kick <= 1'b0;
            r_chk <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kick <= 1'b0;
                        r_chk <= 1'b0;
                        if (!r_fault) begin
                            if (i_q_item.is_tick) begin
                                r_kick <= 1'b1;
                                r_elapsed <= w_el_sat;
                            end else if (i_q_item.who_ok) begin
                                r_acc[w_addr] <= w_acc_sat;
                            end else begin
                                r_fault <= 1'b1;
                                r_fault_kind <= twm_pkg::KIND_INVALID;
                                r_fault_reporter <= i_q_item.who;
                                r_fault_ms <= 32'd0;
                            end
                        end
                    end
                end
                S_MUL3: r_idx <= '0;
                S_WALK: begin
                    if (w_walk_end) begin
                        r_chk <= 1'b1;
                        r_elapsed <= 32'd0;
                    end else if (w_in_win) begin
                        r_acc[w_addr] <= 32'd0;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_chk <= 1'b1;
                        r_elapsed <= 32'd0;
                        r_fault <= 1'b1;
                        r_fault_kind <= twm_pkg::KIND_WINDOW;
                        r_fault_reporter <= 3'(r_idx);
                        r_fault_ms <= w_acc_rd;
                    end
                end
                default: ;
            endcase
            if (r_state == S_EMIT && w_emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL1: r_total <= 24'(i_cfg.check_interval) * 24'(i_cfg.expected_ms);
            S_MUL2: r_plo <= 32'(r_total) * 32'(i_cfg.min_percent);
            S_MUL3: r_phi <= 32'(r_total) * 32'(i_cfg.max_percent);
            default: ;
        endcase
        if (r_state == S_EMIT && w_emit_go) begin
            r_out_kick <= r_kick;
            r_out_chk <= r_chk;
            r_out_fault <= r_fault;
            r_out_kind <= r_fault_kind;
            r_out_reporter <= r_fault_reporter;
            r_out_ms <= r_fault_ms;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kick = r_out_kick;
    assign o_check_done = r_out_chk;
    assign o_fault = r_out_fault;
    assign o_fault_kind = r_out_kind;
    assign o_fault_reporter = r_out_reporter;
    assign o_fault_ms = r_out_ms;

`ifndef SYNTH
    a_fault_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault == (r_fault_kind != twm_pkg::KIND_NONE))
        else $error("fault flag and fault kind disagree");
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("latched fault cleared");
    a_chk_kick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_chk) |-> r_out_kick)
        else $error("check result without kick");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= twm_pkg::CNT_W'(twm_pkg::NUM_REPORTERS))
        else $error("walk index out of range");
`endif

endmodule

/* hdl/task_liveness_window_monitor.sv */
// Top level: configuration registers and the front/back pipeline of the liveness monitor.
// Words go from a 2-word queue, which decouples input from execution, one at a time through
// the back end: idle, then emit; an unfaulted tick adds a time check state, and a check adds
// three multiply states and a walk of one accumulator per cycle over the reporters in use,
// ended early by a window fault; emit waits for the output. Synchronous active-low reset
// restores config defaults and clears the queue, accumulators, timer and fault flags.
module task_liveness_window_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [twm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic [0:0] i_command,
    input  logic [2:0] i_reporter,
    input  logic [15:0] i_amount_ms,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_kick,
    output logic o_check_done,
    output logic o_fault,
    output logic [1:0] o_fault_kind,
    output logic [2:0] o_fault_reporter,
    output logic [31:0] o_fault_ms
);

    logic [15:0] r_tick_ms;
    logic [7:0] r_check_interval;
    logic [15:0] r_expected_ms;
    logic [7:0] r_min_percent;
    logic [7:0] r_max_percent;
    logic [3:0] r_reporters;
    twm_pkg::t_cfg w_cfg;
    logic w_q_valid;
    logic w_q_pop;
    twm_pkg::t_item w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms <= twm_pkg::RST_TICK_MS;
            r_check_interval <= twm_pkg::RST_CHECK_INTERVAL;
            r_expected_ms <= twm_pkg::RST_EXPECTED_MS;
            r_min_percent <= twm_pkg::RST_MIN_PERCENT;
            r_max_percent <= twm_pkg::RST_MAX_PERCENT;
            r_reporters <= twm_pkg::RST_REPORTERS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                twm_pkg::CFG_TICK_MS: r_tick_ms <= i_cfg_data;
                twm_pkg::CFG_CHECK_INTERVAL: r_check_interval <= i_cfg_data[7:0];
                twm_pkg::CFG_EXPECTED_MS: r_expected_ms <= i_cfg_data;
                twm_pkg::CFG_MIN_PERCENT: r_min_percent <= i_cfg_data[7:0];
                twm_pkg::CFG_MAX_PERCENT: r_max_percent <= i_cfg_data[7:0];
                twm_pkg::CFG_REPORTERS: r_reporters <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.tick_ms = r_tick_ms;
        w_cfg.check_interval = r_check_interval;
        w_cfg.expected_ms = r_expected_ms;
        w_cfg.min_percent = r_min_percent;
        w_cfg.max_percent = r_max_percent;
        if (5'(r_reporters) > 5'(twm_pkg::NUM_REPORTERS)) begin
            w_cfg.active = twm_pkg::CNT_W'(twm_pkg::NUM_REPORTERS);
        end else begin
            w_cfg.active = twm_pkg::CNT_W'(r_reporters);
        end
    end

    twm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_reporter  (i_reporter),
        .i_amount_ms (i_amount_ms),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    twm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kick           (o_kick),
        .o_check_done     (o_check_done),
        .o_fault          (o_fault),
        .o_fault_kind     (o_fault_kind),
        .o_fault_reporter (o_fault_reporter),
        .o_fault_ms       (o_fault_ms)
    );

endmodule

/* bench/tb_task_liveness_window_monitor.sv */
// Self-checking bench for the task liveness window monitor: planned and random words, scored.
module tb_task_liveness_window_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import twm_pkg::*;

    localparam int IDLE_PCT = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_SETTLE = 24;
    localparam int MAX_REPORTED = 10;
    localparam int PERCENT_SCALE = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [0:0] command;
        logic [2:0] reporter;
        logic [15:0] amount;
    } monitor_word_t;

    typedef struct packed {
        logic kick;
        logic check_done;
        logic fault;
        logic [1:0] kind;
        logic [2:0] reporter;
        logic [31:0] ms;
    } monitor_status_t;

    typedef struct packed {
        logic [15:0] tick_ms;
        logic [7:0] interval;
        logic [15:0] expected;
        logic [7:0] min_pct;
        logic [7:0] max_pct;
        logic [3:0] reporters;
        logic [NUM_REPORTERS-1:0][31:0] acc;
        logic [31:0] elapsed;
        logic faulted;
        logic [1:0] kind;
        logic [2:0] culprit;
        logic [31:0] culprit_ms;
    } monitor_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [0:0] i_command = CMD_REPORT;
    logic [2:0] i_reporter = '0;
    logic [15:0] i_amount_ms = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_kick;
    logic o_check_done;
    logic o_fault;
    logic [1:0] o_fault_kind;
    logic [2:0] o_fault_reporter;
    logic [31:0] o_fault_ms;

    monitor_state_t bench_model;
    monitor_state_t plan_model;
    monitor_word_t word_backlog[$];
    monitor_status_t predicted_status[$];
    monitor_word_t held_word;
    int unsigned words_issued = 0;
    int unsigned words_completed = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit steady = 1'b0;

    task_liveness_window_monitor uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command(i_command),
        .i_reporter(i_reporter),
        .i_amount_ms(i_amount_ms),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kick(o_kick),
        .o_check_done(o_check_done),
        .o_fault(o_fault),
        .o_fault_kind(o_fault_kind),
        .o_fault_reporter(o_fault_reporter),
        .o_fault_ms(o_fault_ms)
    );

    always #10 i_clk = ~i_clk;

    function automatic monitor_state_t reset_state();
        monitor_state_t s;
        s = '0;
        s.tick_ms = RST_TICK_MS;
        s.interval = RST_CHECK_INTERVAL;
        s.expected = RST_EXPECTED_MS;
        s.min_pct = RST_MIN_PERCENT;
        s.max_pct = RST_MAX_PERCENT;
        s.reporters = RST_REPORTERS;
        return s;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic int active_reporters(input monitor_state_t s);
        return (s.reporters > NUM_REPORTERS) ? NUM_REPORTERS : int'(s.reporters);
    endfunction

    function automatic monitor_word_t make_word(input logic [0:0] cmd, input logic [2:0] who,
                                                input logic [15:0] amt);
        monitor_word_t w;
        w.command = cmd;
        w.reporter = who;
        w.amount = amt;
        return w;
    endfunction

    task automatic window_bounds(input monitor_state_t s, output logic [63:0] lo,
                                 output logic [63:0] hi);
        logic [63:0] total;
        total = 64'(s.interval) * 64'(s.expected);
        lo = total * 64'(s.min_pct) / PERCENT_SCALE;
        hi = total * 64'(s.max_pct) / PERCENT_SCALE;
    endtask

    task automatic check_due(input monitor_state_t s, output bit due);
        due = {32'd0, sat_add(s.elapsed, {16'd0, s.tick_ms})} >= 64'(s.interval) * 64'(MS_PER_SEC);
    endtask

    task automatic write_register(inout monitor_state_t s, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TICK_MS: s.tick_ms = data[15:0];
            CFG_CHECK_INTERVAL: s.interval = data[7:0];
            CFG_EXPECTED_MS: s.expected = data[15:0];
            CFG_MIN_PERCENT: s.min_pct = data[7:0];
            CFG_MAX_PERCENT: s.max_pct = data[7:0];
            CFG_REPORTERS: s.reporters = data[3:0];
            default: ;
        endcase
    endtask

    task automatic advance_monitor(inout monitor_state_t s, input monitor_word_t w,
                                   output monitor_status_t r);
        int n;
        bit due;
        bit stop;
        logic [63:0] lo;
        logic [63:0] hi;
        n = active_reporters(s);
        r = '0;
        if (!s.faulted) begin
            if (w.command == CMD_REPORT) begin
                if (int'(w.reporter) < n) begin
                    s.acc[w.reporter] = sat_add(s.acc[w.reporter], {16'd0, w.amount});
                end else begin
                    s.faulted = 1'b1;
                    s.kind = KIND_INVALID;
                    s.culprit = w.reporter;
                    s.culprit_ms = '0;
                end
            end else begin
                r.kick = 1'b1;
                check_due(s, due);
                s.elapsed = sat_add(s.elapsed, {16'd0, s.tick_ms});
                if (due) begin
                    r.check_done = 1'b1;
                    window_bounds(s, lo, hi);
                    stop = 1'b0;
                    for (int i = 0; i < NUM_REPORTERS; i++) begin
                        if (i < n && !stop) begin
                            if ({32'd0, s.acc[i]} >= lo && {32'd0, s.acc[i]} <= hi) begin
                                s.acc[i] = '0;
                            end else begin
                                s.faulted = 1'b1;
                                s.kind = KIND_WINDOW;
                                s.culprit = 3'(i);
                                s.culprit_ms = s.acc[i];
                                stop = 1'b1;
                            end
                        end
                    end
                    s.elapsed = '0;
                end
            end
        end
        r.fault = s.faulted;
        r.kind = s.kind;
        r.reporter = s.culprit;
        r.ms = s.culprit_ms;
    endtask

    // Steers reports so every reporter sits inside its window before a check tick goes out.
    task automatic plan_word(input monitor_state_t s, output monitor_word_t w);
        int n;
        bit due;
        bit all_ok;
        int unsigned needy[$];
        int unsigned pick;
        int unsigned cap;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] room;
        n = active_reporters(s);
        window_bounds(s, lo, hi);
        check_due(s, due);
        all_ok = 1'b1;
        for (int i = 0; i < n; i++) begin
            if ({32'd0, s.acc[i]} < lo || {32'd0, s.acc[i]} > hi) all_ok = 1'b0;
            if ({32'd0, s.acc[i]} < lo) needy.push_back(i);
        end
        w = make_word(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        if (n != 0 && ((due && !all_ok) || $urandom_range(0, 99) < 60)) begin
            if (needy.size() > 0 && $urandom_range(0, 3) != 0) begin
                pick = needy[$urandom_range(0, needy.size() - 1)];
            end else begin
                pick = $urandom_range(0, n - 1);
            end
            room = (hi > {32'd0, s.acc[pick]}) ? hi - {32'd0, s.acc[pick]} : 64'd0;
            cap = (room > 64'd65535) ? 65535 : int'(room);
            w.command = CMD_REPORT;
            w.reporter = 3'(pick);
            case ($urandom_range(0, 9))
                0: w.amount = '0;
                1: w.amount = 16'(cap);
                default: w.amount = 16'($urandom_range(0, cap));
            endcase
        end
    endtask

    task automatic queue_word(input monitor_word_t w);
        monitor_status_t scratch;
        advance_monitor(plan_model, w, scratch);
        word_backlog.push_back(w);
        words_issued++;
    endtask

    task automatic drain_words();
        while (words_completed < words_issued) @(posedge i_clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        write_register(bench_model, idx, data);
        write_register(plan_model, idx, data);
    endtask

    // Upper data bits carry junk to exercise masking to the register width.
    task automatic apply_settings(input logic [15:0] tick, input logic [7:0] interval,
                                  input logic [15:0] expected, input logic [7:0] min_pct,
                                  input logic [7:0] max_pct, input logic [3:0] reps);
        logic [31:0] junk;
        junk = $urandom;
        program_register(CFG_TICK_MS, tick);
        program_register(CFG_CHECK_INTERVAL, {junk[7:0], interval});
        program_register(CFG_EXPECTED_MS, expected);
        program_register(CFG_MIN_PERCENT, {junk[15:8], min_pct});
        program_register(CFG_MAX_PERCENT, {junk[23:16], max_pct});
        program_register(CFG_REPORTERS, {junk[31:20], reps});
        program_register(CFG_SPARE_A, junk[15:0]);
        program_register(CFG_SPARE_B, junk[31:16]);
    endtask

    task automatic run_phase(input int count, input int noise_pct);
        monitor_word_t w;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) drain_words();
            if ($urandom_range(0, 99) < noise_pct) begin
                w = make_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                              16'($urandom_range(0, 65535)));
            end else begin
                plan_word(plan_model, w);
            end
            queue_word(w);
        end
        drain_words();
    endtask

    task automatic note_mismatch(input monitor_status_t want, input monitor_status_t got,
                                 input bit stray);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            if (stray) begin
                $display("unexpected status word: kick %0d check %0d fault %0d kind %0d rep %0d ms %0d",
                         got.kick, got.check_done, got.fault, got.kind, got.reporter, got.ms);
            end else begin
                $display("mismatch (exp/act): kick %0d/%0d check %0d/%0d fault %0d/%0d kind %0d/%0d rep %0d/%0d ms %0d/%0d",
                         want.kick, got.kick, want.check_done, got.check_done,
                         want.fault, got.fault, want.kind, got.kind,
                         want.reporter, got.reporter, want.ms, got.ms);
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_words
        monitor_status_t st;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_monitor(bench_model, held_word, st);
                predicted_status.push_back(st);
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held_word = word_backlog.pop_front();
                    i_command <= held_word.command;
                    i_reporter <= held_word.reporter;
                    i_amount_ms <= held_word.amount;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_status
        monitor_status_t got;
        monitor_status_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_kick, o_check_done, o_fault, o_fault_kind, o_fault_reporter, o_fault_ms};
                words_completed++;
                if (predicted_status.size() == 0) begin
                    note_mismatch('0, got, 1'b1);
                end else begin
                    want = predicted_status.pop_front();
                    if (got !== want) note_mismatch(want, got, 1'b0);
                end
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : watchdog_limit
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("task_liveness_window_monitor test failed");
            $finish;
        end
    end

    initial begin
        bench_model = reset_state();
        plan_model = reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: one reporter, window 2100..3600, check every third tick
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd1000));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd1100));
        queue_word(make_word(CMD_TICK, 3'd7, 16'hFFFF));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd3600));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd0));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd2500));
        queue_word(make_word(CMD_TICK, 3'd0, 16'd0));
        drain_words();

        apply_settings(16'd1000, 8'd3, 16'd1000, 8'd70, 8'd120, 4'd8);
        run_phase(230, 0);

        apply_settings(16'd65535, 8'd255, 16'd1, 8'd0, 8'd255, 4'd8);
        run_phase(230, 0);

        // zero interval: every tick checks against a zero-width window at 0
        apply_settings(16'd1, 8'd0, 16'd65535, 8'd255, 8'd0, 4'd15);
        run_phase(200, 0);

        // no reporters in use: checks walk nothing
        apply_settings(16'd300, 8'd1, 16'd1000, 8'd70, 8'd120, 4'd0);
        run_phase(200, 0);

        // zero tick: elapsed never moves, accumulators run up
        apply_settings(16'd0, 8'd255, 16'd65535, 8'd0, 8'd255, 4'd8);
        queue_word(make_word(CMD_REPORT, 3'd7, 16'hFFFF));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd7, 16'd0));
        queue_word(make_word(CMD_REPORT, 3'd0, 16'hFFFF));
        queue_word(make_word(CMD_TICK, 3'd5, 16'h5A5A));
        run_phase(230, 0);

        steady = 1'b1;
        apply_settings(16'd700, 8'd2, 16'd2000, 8'd50, 8'd150, 4'd5);
        run_phase(240, 0);
        steady = 1'b0;

        apply_settings(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        run_phase(250, 40);

        drain_words();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0 && predicted_status.size() == 0) begin
            $display("task_liveness_window_monitor test passed");
        end else begin
            $display("task_liveness_window_monitor test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/twm_pkg.sv
hdl/twm_front.sv
hdl/twm_back.sv
hdl/task_liveness_window_monitor.sv
bench/tb_task_liveness_window_monitor.sv
